>>> sv/lic_pkg.sv
// ----------------------------------------------------------------------------
// lic_pkg: lattice index converter shared definitions
// Widths, pipeline sizing and the item, config and stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package lic_pkg;

    localparam int MAX_DIMS       = 4;
    localparam int COORD_BITS     = 8;
    localparam int NUM_AXES       = 4;
    localparam int IDX_W          = 32;
    localparam int SIDE_W         = 9;
    localparam int DIMS_W         = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = SIDE_W;
    localparam int SIDE_MAX       = 256;
    localparam int CMAX           = (2 ** COORD_BITS) - 1;
    // remainder of a division by side is below side, so one bit narrower
    localparam int REM_W          = SIDE_W - 1;
    // low quotient window: wide enough for the range test and the saturation test
    localparam int QWIN_W         = (COORD_BITS + 1 > SIDE_W) ? COORD_BITS + 1 : SIDE_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int NUM_STAGES     = IDX_W / BITS_PER_STAGE;
    localparam int DEC_LAT        = NUM_STAGES + 1;
    localparam int ENC_LAT        = MAX_DIMS;

    // request operations
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIMS = CFG_IDX_W'(1);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic               cmd;
        t_coord             coord_0;
        t_coord             coord_1;
        t_coord             coord_2;
        t_coord             coord_3;
        logic [IDX_W-1:0]   site_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   index_out;
        t_coord             axis0_out;
        t_coord             axis1_out;
        t_coord             axis2_out;
        t_coord             axis3_out;
        logic               out_of_range;
    } t_out_item;

    // effective (clamped) configuration
    typedef struct packed {
        logic [SIDE_W-1:0]  side;
        logic [DIMS_W-1:0]  dims;
    } t_cfg;

    // decode pipeline word: level k holds quotient floor(index / side^k)
    typedef struct packed {
        logic                               cmd;
        logic [MAX_DIMS-1:0][REM_W-1:0]     rem;
        logic [MAX_DIMS-1:0][QWIN_W-1:0]    win;
        logic [MAX_DIMS-1:0]                big;
        logic [IDX_W-1:0]                   dividend;
    } t_dstage;

    typedef struct packed {
        logic                               cmd;
        logic [NUM_AXES-1:0][COORD_BITS-1:0] axis;
        logic                               oor;
    } t_dec_res;

endpackage

`default_nettype wire

>>> sv/lic_dstage.sv
// ----------------------------------------------------------------------------
// lic_dstage: one decode pipeline stage
// Shifts two index bits through a cascade of restoring divide-by-side steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_dstage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lic_pkg::t_cfg     i_cfg,
    input  logic              i_vld,
    input  lic_pkg::t_dstage  i_data,
    output logic              o_vld,
    output lic_pkg::t_dstage  o_data
);
    import lic_pkg::*;

    logic    r_vld;
    t_dstage r_data;
    t_dstage n_data;

    // quotient bit of level k-1 feeds the divider that builds level k
    always_comb begin
        logic [SIDE_W-1:0] v_t;
        logic              v_q;
        n_data = i_data;
        v_t    = '0;
        v_q    = 1'b0;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            v_q             = n_data.dividend[IDX_W-1];
            n_data.dividend = {n_data.dividend[IDX_W-2:0], 1'b0};
            for (int k = 1; k < MAX_DIMS; k++) begin
                v_t = {n_data.rem[k-1], v_q};
                if (v_t >= i_cfg.side) begin
                    n_data.rem[k-1] = REM_W'(v_t - i_cfg.side);
                    v_q             = 1'b1;
                end else begin
                    n_data.rem[k-1] = v_t[REM_W-1:0];
                    v_q             = 1'b0;
                end
                n_data.big[k] = n_data.big[k] | n_data.win[k][QWIN_W-1];
                n_data.win[k] = {n_data.win[k][QWIN_W-2:0], v_q};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

>>> sv/lic_dec.sv
// ----------------------------------------------------------------------------
// lic_dec: index to coordinates decoder
// Entry register, bit-serial division pipeline and final axis selection.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_dec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lic_pkg::t_cfg              i_cfg,
    input  logic                       i_vld,
    input  logic                       i_cmd,
    input  logic [lic_pkg::IDX_W-1:0]  i_index,
    output logic                       o_vld,
    output lic_pkg::t_dec_res          o_res
);
    import lic_pkg::*;

    logic    r_entry_vld;
    t_dstage r_entry;
    t_dstage n_entry;

    t_dstage s_data [NUM_STAGES+1];
    logic    s_vld  [NUM_STAGES+1];

    // level 0 is the index itself; its window is loaded directly
    always_comb begin
        n_entry          = '0;
        n_entry.cmd      = i_cmd;
        n_entry.dividend = i_index;
        n_entry.win[0]   = i_index[QWIN_W-1:0];
        n_entry.big[0]   = |i_index[IDX_W-1:QWIN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= 1'b0;
        end else begin
            r_entry_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign s_vld[0]  = r_entry_vld;
    assign s_data[0] = r_entry;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        lic_dstage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (i_cfg),
            .i_vld   (s_vld[g]),
            .i_data  (s_data[g]),
            .o_vld   (s_vld[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    // top active axis takes the whole quotient, lower axes the remainders
    always_comb begin
        t_dstage           v_last;
        logic [QWIN_W-1:0] v_win;
        logic              v_big;
        logic              v_sat;
        v_last = s_data[NUM_STAGES];
        v_win  = '0;
        v_big  = 1'b0;
        for (int lv = 0; lv < MAX_DIMS; lv++) begin
            if (lv == int'(i_cfg.dims) - 1) begin
                v_win = v_last.win[lv];
                v_big = v_last.big[lv];
            end
        end
        v_sat      = v_big || (v_win > QWIN_W'(CMAX));
        o_res.cmd  = v_last.cmd;
        o_res.oor  = v_big || (v_win >= QWIN_W'(i_cfg.side));
        o_res.axis = '0;
        for (int a = 0; a < NUM_AXES && a < MAX_DIMS; a++) begin
            if (a == int'(i_cfg.dims) - 1) begin
                o_res.axis[a] = v_sat ? COORD_BITS'(CMAX) : v_win[COORD_BITS-1:0];
            end else if (a < int'(i_cfg.dims) - 1) begin
                o_res.axis[a] = COORD_BITS'(v_last.rem[a]);
            end
        end
    end

    assign o_vld = s_vld[NUM_STAGES];

endmodule

`default_nettype wire

>>> sv/lic_enc.sv
// ----------------------------------------------------------------------------
// lic_enc: coordinates to index encoder
// Horner evaluation, one multiply-add by side per stage, top axis first.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_enc (
    input  logic                       i_clk,
    input  lic_pkg::t_cfg              i_cfg,
    input  lic_pkg::t_in_item          i_item,
    output logic [lic_pkg::IDX_W-1:0]  o_index
);
    import lic_pkg::*;

    typedef struct packed {
        logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord;
        logic [IDX_W-1:0]                    acc;
    } t_enc;

    t_enc r_enc [MAX_DIMS];
    t_enc n_enc [MAX_DIMS];

    // inactive axes are zeroed so they drop out of the sum
    always_comb begin
        logic [NUM_AXES-1:0][COORD_BITS-1:0] v_cin;
        v_cin = {i_item.coord_3, i_item.coord_2, i_item.coord_1, i_item.coord_0};
        n_enc[0] = '0;
        for (int k = 0; k < MAX_DIMS && k < NUM_AXES; k++) begin
            if (k < int'(i_cfg.dims)) begin
                n_enc[0].coord[k] = v_cin[k];
            end
        end
        n_enc[0].acc = IDX_W'(n_enc[0].coord[MAX_DIMS-1]);
    end

    always_ff @(posedge i_clk) begin
        r_enc[0] <= n_enc[0];
    end

    for (genvar s = 1; s < MAX_DIMS; s++) begin : g_step
        localparam int AX = MAX_DIMS - 1 - s;

        always_comb begin
            n_enc[s].coord = r_enc[s-1].coord;
            n_enc[s].acc   = IDX_W'(r_enc[s-1].acc * IDX_W'(i_cfg.side))
                           + IDX_W'(r_enc[s-1].coord[AX]);
        end

        always_ff @(posedge i_clk) begin
            r_enc[s] <= n_enc[s];
        end
    end

    assign o_index = r_enc[MAX_DIMS-1].acc;

endmodule

`default_nettype wire

>>> sv/lattice_index_convert_top.sv
// ----------------------------------------------------------------------------
// lattice_index_convert_top: lattice site index converter
// Encodes coordinates to a linear index or decodes an index to coordinates.
// ----------------------------------------------------------------------------
// Pipeline: input register, decode entry register, the 16-stage bit-serial
//   divider (2 bits/stage) and the output register lead from start to the result strobe.
// Throughput: one request per cycle while busy is low; the receiver cannot stall.
// Reset: synchronous; busy and cfg_ready stay high/low through reset, the
//   pipeline empties, side returns to 16 and dims to 4.
`default_nettype none

module lattice_index_convert_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  lic_pkg::t_in_item               i_item,
    output logic                            busy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lic_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lic_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_result_valid,
    output lic_pkg::t_out_item              o_result
);
    import lic_pkg::*;

    localparam int                   SIDE_RST    = 16;
    localparam int                   DIMS_RST    = 4;
    localparam int                   ENC_PAD     = DEC_LAT - ENC_LAT;
    localparam int                   RES_DELAY   = DEC_LAT + 2;

    logic              r_busy;
    logic [SIDE_W-1:0] r_side;
    logic [DIMS_W-1:0] r_dims;
    t_cfg              s_cfg;

    logic              r_in_vld;
    t_in_item          r_in;

    logic              s_dec_vld;
    t_dec_res          s_dec;
    logic [IDX_W-1:0]  s_enc_index;
    logic [IDX_W-1:0]  r_enc_dly [ENC_PAD];

    logic              r_out_vld;
    t_out_item         r_out;
    t_out_item         n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(SIDE_RST);
            r_dims <= DIMS_W'(DIMS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIDE: begin
                    r_side <= i_cfg_data[SIDE_W-1:0];
                end
                REG_DIMS: begin
                    r_dims <= i_cfg_data[DIMS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp side to 1..256 and dims to 1..MAX_DIMS
    always_comb begin
        s_cfg.side = r_side;
        if (r_side == '0) begin
            s_cfg.side = SIDE_W'(1);
        end else if (r_side > SIDE_W'(SIDE_MAX)) begin
            s_cfg.side = SIDE_W'(SIDE_MAX);
        end
        s_cfg.dims = r_dims;
        if (r_dims == '0) begin
            s_cfg.dims = DIMS_W'(1);
        end else if (int'(r_dims) > MAX_DIMS) begin
            s_cfg.dims = DIMS_W'(MAX_DIMS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    lic_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (s_cfg),
        .i_vld   (r_in_vld),
        .i_cmd   (r_in.cmd),
        .i_index (r_in.site_index),
        .o_vld   (s_dec_vld),
        .o_res   (s_dec)
    );

    lic_enc u_enc (
        .i_clk   (i_clk),
        .i_cfg   (s_cfg),
        .i_item  (r_in),
        .o_index (s_enc_index)
    );

    // line up the encoder result with the longer decode path
    always_ff @(posedge i_clk) begin
        r_enc_dly[0] <= s_enc_index;
        for (int i = 1; i < ENC_PAD; i++) begin
            r_enc_dly[i] <= r_enc_dly[i-1];
        end
    end

    always_comb begin
        n_out = '0;
        if (s_dec.cmd == CMD_ENCODE) begin
            n_out.index_out = r_enc_dly[ENC_PAD-1];
        end else begin
            n_out.axis0_out    = s_dec.axis[0];
            n_out.axis1_out    = s_dec.axis[1];
            n_out.axis2_out    = s_dec.axis[2];
            n_out.axis3_out    = s_dec.axis[3];
            n_out.out_of_range = s_dec.oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= s_dec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    // every taken request gives one result a fixed time later, and only then
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##RES_DELAY o_result_valid)
        else $error("request without a result at the fixed latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, RES_DELAY))
        else $error("result transfer without a matching request");

    // range flag only comes from a decode, which carries a zero index
    a_oor_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.out_of_range) |-> (o_result.index_out == '0))
        else $error("range flag on an encode result");

endmodule

`default_nettype wire

>>> test/tb_lattice_index_convert_top.sv
// ----------------------------------------------------------------------------
// tb_lattice_index_convert_top: lattice index converter testbench
// Directed corner requests, then phases of random encode and decode requests
// under random side and dimension settings. Each result is checked field by
// field against a local prediction, in request order.
// ----------------------------------------------------------------------------
module tb_lattice_index_convert_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lic_pkg::*;

    localparam int RESULT_LATENCY  = 19;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int REPORT_LIMIT    = 100;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    t_in_item              i_item = '0;
    logic                  busy;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_result_valid;
    t_out_item             o_result;

    t_in_item          request_q[$];
    t_out_item         conversion_q[$];
    t_reg_write        reg_write_q[$];
    logic [SIDE_W-1:0] side_reg = 9'd16;
    logic [DIMS_W-1:0] dims_reg = 3'd4;
    int                mismatch_count = 0;
    int                stall_cycles = 0;
    int                gap_left = 0;
    bit                no_idle = 1'b0;

    lattice_index_convert_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned active_side(logic [SIDE_W-1:0] raw);
        if (raw == 0) return 64'd1;
        if (raw > SIDE_MAX) return 64'(SIDE_MAX);
        return 64'(raw);
    endfunction

    function automatic int active_dims(logic [DIMS_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIMS) return MAX_DIMS;
        return int'(raw);
    endfunction

    function automatic t_coord clip_coord(longint unsigned q);
        return (q > CMAX) ? t_coord'(CMAX) : t_coord'(q);
    endfunction

    // mixed-radix conversion under the given (raw) register values
    function automatic t_out_item convert_site(t_in_item req, logic [SIDE_W-1:0] side_raw,
                                               logic [DIMS_W-1:0] dims_raw);
        longint unsigned side, place, rest, q;
        int              dims;
        t_coord          coords[NUM_AXES];
        t_coord          axes[NUM_AXES];
        t_out_item       res;
        side = active_side(side_raw);
        dims = active_dims(dims_raw);
        res = '0;
        foreach (axes[a]) axes[a] = '0;
        if (req.cmd == CMD_ENCODE) begin
            coords = '{req.coord_0, req.coord_1, req.coord_2, req.coord_3};
            place = 1;
            rest = 0;
            for (int d = 0; d < dims; d++) begin
                rest = (rest + coords[d] * place) & 64'hFFFF_FFFF;
                place = (place * side) & 64'hFFFF_FFFF;
            end
            res.index_out = rest[IDX_W-1:0];
        end else begin
            rest = 64'(req.site_index);
            place = 1;
            for (int d = 1; d < dims; d++) place = place * side;
            // top axis takes the whole quotient, which also sets the range flag
            q = rest / place;
            res.out_of_range = (q >= side);
            axes[dims-1] = clip_coord(q);
            rest = rest % place;
            for (int d = dims - 2; d >= 0; d--) begin
                place = place / side;
                axes[d] = clip_coord(rest / place);
                rest = rest % place;
            end
            res.axis0_out = axes[0];
            res.axis1_out = axes[1];
            res.axis2_out = axes[2];
            res.axis3_out = axes[3];
        end
        return res;
    endfunction

    // random request, mostly within the active lattice
    function automatic t_in_item make_request(logic [SIDE_W-1:0] side_raw,
                                              logic [DIMS_W-1:0] dims_raw);
        longint unsigned side, size;
        int              dims, pick;
        t_in_item        req;
        side = active_side(side_raw);
        dims = active_dims(dims_raw);
        size = 1;
        for (int d = 0; d < dims; d++) size = size * side;
        req.cmd = 1'($urandom_range(0, 1));
        req.coord_0 = t_coord'($urandom);
        req.coord_1 = t_coord'($urandom);
        req.coord_2 = t_coord'($urandom);
        req.coord_3 = t_coord'($urandom);
        req.site_index = $urandom;
        pick = $urandom_range(0, 9);
        if (req.cmd == CMD_ENCODE) begin
            if (pick < 7) begin
                req.coord_0 = t_coord'($urandom % side);
                req.coord_1 = t_coord'($urandom % side);
                req.coord_2 = t_coord'($urandom % side);
                req.coord_3 = t_coord'($urandom % side);
            end
        end else if (pick < 6) begin
            req.site_index = IDX_W'({32'b0, $urandom} % size);
        end else if (pick < 8) begin
            // around the lattice size
            req.site_index = IDX_W'(size - 1 + $urandom_range(0, 2));
        end
        return req;
    endfunction

    function automatic int draw_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatch_count < REPORT_LIMIT)
            $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    task automatic push_encode(t_coord c0, t_coord c1, t_coord c2, t_coord c3);
        t_in_item req;
        req.cmd = CMD_ENCODE;
        req.coord_0 = c0;
        req.coord_1 = c1;
        req.coord_2 = c2;
        req.coord_3 = c3;
        req.site_index = $urandom;
        request_q.push_back(req);
    endtask

    task automatic push_decode(logic [IDX_W-1:0] index);
        t_in_item req;
        req.cmd = CMD_DECODE;
        req.coord_0 = t_coord'($urandom);
        req.coord_1 = t_coord'($urandom);
        req.coord_2 = t_coord'($urandom);
        req.coord_3 = t_coord'($urandom);
        req.site_index = index;
        request_q.push_back(req);
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || start || conversion_q.size() > 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_lattice(logic [SIDE_W-1:0] side, logic [DIMS_W-1:0] dims);
        t_reg_write w;
        wait_drained();
        w.index = REG_SIDE;
        w.data = side;
        reg_write_q.push_back(w);
        // junk above the dims field must be dropped
        w.index = REG_DIMS;
        w.data = CFG_DATA_W'($urandom);
        w.data[DIMS_W-1:0] = dims;
        reg_write_q.push_back(w);
        do @(negedge i_clk); while (reg_write_q.size() > 0 || i_cfg_valid);
    endtask

    // request side: one transfer per start/!busy edge, random gaps in between
    always @(posedge i_clk) begin : request_driver
        logic next_start;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
            gap_left <= 0;
        end else if (!start || !busy) begin
            if (start) conversion_q.push_back(convert_site(i_item, side_reg, dims_reg));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                next_start = 1'b0;
            end else if (request_q.size() > 0) begin
                i_item <= request_q.pop_front();
                next_start = 1'b1;
                gap_left <= draw_gap();
            end else begin
                next_start = 1'b0;
            end
        end
        start <= next_start;
    end

    always @(posedge i_clk) begin : cfg_driver
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            side_reg <= 9'd16;
            dims_reg <= 3'd4;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIDE: side_reg <= i_cfg_data[SIDE_W-1:0];
                    REG_DIMS: dims_reg <= i_cfg_data[DIMS_W-1:0];
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_write_q.size() > 0) begin
                    w = reg_write_q.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.index;
                    i_cfg_data <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (conversion_q.size() == 0) begin
                report_mismatch("unexpected result, index_out", 64'(o_result.index_out),
                                64'd0);
            end else begin
                want = conversion_q.pop_front();
                check_field("index_out", 64'(o_result.index_out), 64'(want.index_out));
                check_field("axis0_out", 64'(o_result.axis0_out), 64'(want.axis0_out));
                check_field("axis1_out", 64'(o_result.axis1_out), 64'(want.axis1_out));
                check_field("axis2_out", 64'(o_result.axis2_out), 64'(want.axis2_out));
                check_field("axis3_out", 64'(o_result.axis3_out), 64'(want.axis3_out));
                check_field("out_of_range", 64'(o_result.out_of_range),
                            64'(want.out_of_range));
            end
        end
    end

    // ends the run if no expected transfer of any kind happens for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || (o_result_valid && conversion_q.size() > 0) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [SIDE_W-1:0] side;
        logic [DIMS_W-1:0] dims;
        int                pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: side 16, four axes
        push_encode(8'd0, 8'd0, 8'd0, 8'd0);
        push_encode(8'd255, 8'd255, 8'd255, 8'd255);
        push_encode(8'd15, 8'd15, 8'd15, 8'd15);
        push_decode(32'd0);
        push_decode(32'd65535);
        push_decode(32'd65536);
        push_decode(32'hFFFF_FFFF);

        set_lattice(9'd256, 3'd4);
        push_decode(32'hFFFF_FFFF);
        push_encode(8'd255, 8'd255, 8'd255, 8'd255);
        push_decode(32'h1234_5678);

        // zero side and zero dims both act as one
        set_lattice(9'd0, 3'd0);
        push_decode(32'd0);
        push_decode(32'd1);
        push_encode(8'd7, 8'd9, 8'd9, 8'd9);

        set_lattice(9'd511, 3'd7);
        push_decode(32'hFFFF_FFFF);
        push_encode(8'd1, 8'd2, 8'd3, 8'd4);

        set_lattice(9'd1, 3'd4);
        push_decode(32'd0);
        push_decode(32'd300);
        push_encode(8'd5, 8'd6, 8'd7, 8'd8);

        set_lattice(9'd2, 3'd3);
        push_decode(32'd7);
        push_decode(32'd8);
        push_encode(8'd1, 8'd1, 8'd1, 8'd1);

        set_lattice(9'd200, 3'd2);
        push_decode(32'd39999);
        push_decode(32'd40000);
        push_encode(8'd255, 8'd255, 8'd0, 8'd0);

        set_lattice(9'd3, 3'd5);
        push_decode(32'd80);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                case ($urandom_range(0, 5))
                    0: side = 9'd0;
                    1: side = 9'd1;
                    2: side = 9'd2;
                    3: side = 9'd256;
                    4: side = 9'd257;
                    default: side = 9'd511;
                endcase
            end else if (pick < 7) begin
                side = SIDE_W'($urandom_range(2, 20));
            end else begin
                side = SIDE_W'($urandom_range(21, 300));
            end
            dims = DIMS_W'($urandom_range(0, 7));
            set_lattice(side, dims);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                request_q.push_back(make_request(side, dims));
        end

        wait_drained();
        repeat (RESULT_LATENCY + 5) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
